@@ rtl/s2gc_pkg.sv @@
// ----------------------------------------------------------------------------
// Step-two sequence gap checker: shared definitions
// Field widths, function and status codes, and the request and result
// structures that pass between the channel interfaces and the checker core.
// ----------------------------------------------------------------------------
package s2gc_pkg;

  // Field widths
  localparam int SeqW      = 64;
  localparam int LenW      = 15;
  localparam int StatusW   = 3;
  localparam int BytesW    = 40;
  localparam int PktsW     = 32;
  localparam int LimitW    = 64;
  // Width that holds any frame cap in the parameter range
  localparam int FrameCapW = 17;

  localparam int MaxFrameDefault = 16384;
  localparam logic [LenW-1:0] MinFrame = LenW'(8);

  // Function codes of an input request
  localparam logic FuncPacket = 1'b0;
  localparam logic FuncTick   = 1'b1;

  typedef enum logic [StatusW-1:0] {
    ST_IN_ORDER = 3'd0,
    ST_FIRST    = 3'd1,
    ST_GAP      = 3'd2,
    ST_PARITY   = 3'd3,
    ST_STALE    = 3'd4,
    ST_RUNT     = 3'd5,
    ST_LIMIT    = 3'd6,
    ST_REPORT   = 3'd7
  } status_e;

  typedef struct packed {
    logic            func;
    logic [SeqW-1:0] seq_number;
    logic [LenW-1:0] frame_length;
  } item_t;

  typedef struct packed {
    status_e           status;
    logic [SeqW-1:0]   packets_total;
    logic [SeqW-1:0]   lost_total;
    logic [SeqW-1:0]   parity_total;
    logic [BytesW-1:0] interval_bytes;
    logic [PktsW-1:0]  interval_packets;
  } result_t;

endpackage

@@ rtl/s2gc_chan_if.sv @@
// ----------------------------------------------------------------------------
// Step-two sequence gap checker: valid/ready channel
// One request moves at a rising edge where valid and ready are both high.
// ----------------------------------------------------------------------------
interface s2gc_chan_if #(
  parameter type T = logic
);

  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

@@ rtl/step2_sequence_gap_checker_top.sv @@
// ----------------------------------------------------------------------------
// Step-two sequence gap checker: top level
// Input register, checker core and result register with valid/ready
// channels for requests, results and the packet limit register.
// ----------------------------------------------------------------------------
// A request is held in the input register, and its result is registered in the
// result register. Throughput: one request per cycle while results are taken, set
// by the combinational checker core between the input register and the result register.
// The packet limit write is taken in any cycle (ready is always high).
// Reset clears all counters, the expected value and the limit; no clearing
// pass follows, so the block takes requests from the first cycle after reset.
module step2_sequence_gap_checker_top #(
  parameter int MAX_FRAME = s2gc_pkg::MaxFrameDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  s2gc_chan_if.sink   item_i,
  s2gc_chan_if.source result_o,
  s2gc_chan_if.sink   cfg_i
);
  import s2gc_pkg::*;

  logic    item_valid_q, item_valid_d;
  item_t   item_q;
  logic    res_valid_q, res_valid_d;
  result_t res_q;
  result_t core_res;
  logic    advance;
  logic    accept;
  logic    fire;

  // Move the held request on when the result register is free
  assign advance      = !res_valid_q || result_o.ready;
  assign item_i.ready = !item_valid_q || advance;
  assign accept       = item_i.valid && item_i.ready;
  assign fire         = item_valid_q && advance;

  assign cfg_i.ready = 1'b1;

  s2gc_core #(
    .MAX_FRAME (MAX_FRAME)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (fire),
    .item_i     (item_q),
    .cfg_we_i   (cfg_i.valid),
    .cfg_data_i (cfg_i.data),
    .result_o   (core_res)
  );

  // Next valid flags for both registers
  always_comb begin
    item_valid_d = item_valid_q;
    if (accept) begin
      item_valid_d = 1'b1;
    end else if (fire) begin
      item_valid_d = 1'b0;
    end
    res_valid_d = res_valid_q;
    if (fire) begin
      res_valid_d = 1'b1;
    end else if (result_o.ready) begin
      res_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
      res_valid_q  <= 1'b0;
    end else begin
      item_valid_q <= item_valid_d;
      res_valid_q  <= res_valid_d;
    end
  end

  // Capture the request and the result payloads
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_i.data;
    end
    if (fire) begin
      res_q <= core_res;
    end
  end

  assign result_o.valid = res_valid_q;
  assign result_o.data  = res_q;

  // A processed request always lands in the result register
  assert property (@(posedge clk_i) disable iff (!rst_ni) fire |=> res_valid_q)
    else $error("processed request produced no result");

  // A held request waits while the result register is blocked
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_valid_q && !advance |=> item_valid_q && $stable(item_q))
    else $error("held request dropped or changed under stall");

  // A result appears only from a held request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_valid_q) |-> $past(item_valid_q))
    else $error("result appeared without a request");

endmodule

@@ rtl/s2gc_core.sv @@
// ----------------------------------------------------------------------------
// Step-two sequence gap checker: checker core
// Holds the sequence tracking state, the totals and the interval counters,
// classifies one request per cycle while fire_i is high and presents its result combinationally.
// ----------------------------------------------------------------------------
module s2gc_core #(
  parameter int MAX_FRAME = s2gc_pkg::MaxFrameDefault
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                fire_i,
  input  s2gc_pkg::item_t                     item_i,
  input  logic                                cfg_we_i,
  input  logic [s2gc_pkg::LimitW-1:0]         cfg_data_i,
  output s2gc_pkg::result_t                   result_o
);
  import s2gc_pkg::*;

  localparam int AddW = $clog2(MAX_FRAME + 1);
  localparam logic [FrameCapW-1:0] MaxFrameCap = FrameCapW'(MAX_FRAME);

  logic [LimitW-1:0] limit_q;
  logic [SeqW-1:0]   expected_q, expected_d;
  logic              exp_valid_q, exp_valid_d;
  logic [SeqW-1:0]   accepted_q, accepted_d;
  logic [SeqW-1:0]   lost_q, lost_d;
  logic [SeqW-1:0]   parity_q, parity_d;
  logic [BytesW-1:0] bytes_q, bytes_d;
  logic [PktsW-1:0]  pkts_q, pkts_d;

  logic              limit_hit;
  logic              runt;
  logic [SeqW:0]     diff;
  logic              ahead;
  logic              same;
  logic [FrameCapW-1:0] len_ext;
  logic [AddW-1:0]   add;
  logic [BytesW:0]   bytes_sum;
  status_e           status;

  // Cap the byte count at the receive buffer size
  assign len_ext = FrameCapW'(item_i.frame_length);
  assign add     = AddW'((len_ext > MaxFrameCap) ? MaxFrameCap : len_ext);

  // Compare against the expected value with one subtract
  assign diff  = {1'b0, item_i.seq_number} - {1'b0, expected_q};
  assign same  = (diff == '0);
  assign ahead = !diff[SeqW] && !same;

  assign limit_hit = (limit_q != '0) && (accepted_q >= limit_q);
  assign runt      = (item_i.frame_length < MinFrame);
  assign bytes_sum = {1'b0, bytes_q} + (BytesW + 1)'(add);

  // Classify the request and work out the next state
  always_comb begin
    expected_d  = expected_q;
    exp_valid_d = exp_valid_q;
    accepted_d  = accepted_q;
    lost_d      = lost_q;
    parity_d    = parity_q;
    bytes_d     = bytes_q;
    pkts_d      = pkts_q;
    status      = ST_REPORT;
    if (item_i.func == FuncTick) begin
      bytes_d = '0;
      pkts_d  = '0;
      status  = ST_REPORT;
    end else if (limit_hit) begin
      status = ST_LIMIT;
    end else if (runt) begin
      status = ST_RUNT;
    end else begin
      if (!exp_valid_q) begin
        expected_d  = item_i.seq_number + SeqW'(2);
        exp_valid_d = 1'b1;
        status      = ST_FIRST;
      end else if (same) begin
        expected_d = item_i.seq_number + SeqW'(2);
        status     = ST_IN_ORDER;
      end else if (ahead) begin
        if (diff[0]) begin
          parity_d = parity_q + SeqW'(1);
          status   = ST_PARITY;
        end else begin
          lost_d = lost_q + {1'b0, diff[SeqW-1:1]};
          status = ST_GAP;
        end
        expected_d = item_i.seq_number + SeqW'(2);
      end else begin
        status = ST_STALE;
      end
      accepted_d = accepted_q + SeqW'(1);
      pkts_d     = (pkts_q == '1) ? pkts_q : pkts_q + PktsW'(1);
      bytes_d    = bytes_sum[BytesW] ? '1 : bytes_sum[BytesW-1:0];
    end
  end

  // Report totals after the update; a tick reports the interval before clear
  always_comb begin
    result_o.status           = status;
    result_o.packets_total    = accepted_d;
    result_o.lost_total       = lost_d;
    result_o.parity_total     = parity_d;
    result_o.interval_bytes   = (item_i.func == FuncTick) ? bytes_q : bytes_d;
    result_o.interval_packets = (item_i.func == FuncTick) ? pkts_q : pkts_d;
  end

  // Hold the packet limit register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= '0;
    end else if (cfg_we_i) begin
      limit_q <= cfg_data_i;
    end
  end

  // Advance the state on each processed request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_q  <= '0;
      exp_valid_q <= 1'b0;
      accepted_q  <= '0;
      lost_q      <= '0;
      parity_q    <= '0;
      bytes_q     <= '0;
      pkts_q      <= '0;
    end else if (fire_i) begin
      expected_q  <= expected_d;
      exp_valid_q <= exp_valid_d;
      accepted_q  <= accepted_d;
      lost_q      <= lost_d;
      parity_q    <= parity_d;
      bytes_q     <= bytes_d;
      pkts_q      <= pkts_d;
    end
  end

  // Once a first packet is seen the expected value stays valid
  assert property (@(posedge clk_i) disable iff (!rst_ni) !$fell(exp_valid_q))
    else $error("expected value lost its valid flag");

  // A tick leaves the interval counters cleared
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && (item_i.func == FuncTick) |=> (bytes_q == '0) && (pkts_q == '0))
    else $error("interval counters not cleared by tick");

  // Without a processed request the totals stay put
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fire_i |=> $stable(accepted_q) && $stable(lost_q) && $stable(parity_q))
    else $error("totals moved without a request");

  // Once the limit is reached a packet is not counted
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && (item_i.func == FuncPacket) && limit_hit |=> $stable(accepted_q))
    else $error("packet counted beyond the limit");

endmodule

@@ sim/tb_top.sv @@
// ----------------------------------------------------------------------------
// Step-two sequence gap checker: testbench
// Drives packet and tick requests with random sender gaps and receiver stalls.
// A scoreboard predicts every result, in order, and compares each field.
// The packet limit is changed between phases: none, the largest value, a
// value just above the packets taken so far, one, and none again.
// ----------------------------------------------------------------------------
module tb_top;

  timeunit 1ns;
  timeprecision 1ps;

  import s2gc_pkg::*;

  localparam int          FrameCap   = 16384;
  localparam int unsigned CycleLimit = 500000;
  localparam int unsigned SettleCyc  = 4;

  // Predicts the checker's results and compares them with what comes back
  class gap_scoreboard;
    logic [LimitW-1:0] pkt_cap;
    logic [SeqW-1:0]   next_seq;
    bit                seq_locked;
    logic [SeqW-1:0]   pkt_total;
    logic [SeqW-1:0]   lost_sum;
    logic [SeqW-1:0]   parity_sum;
    logic [BytesW-1:0] win_bytes;
    logic [PktsW-1:0]  win_pkts;
    result_t           awaiting[$];
    int unsigned       errors;

    function new();
      pkt_cap    = '0;
      next_seq   = '0;
      seq_locked = 1'b0;
      pkt_total  = '0;
      lost_sum   = '0;
      parity_sum = '0;
      win_bytes  = '0;
      win_pkts   = '0;
      errors     = 0;
    endfunction

    function result_t snapshot(status_e st);
      result_t r;
      r.status           = st;
      r.packets_total    = pkt_total;
      r.lost_total       = lost_sum;
      r.parity_total     = parity_sum;
      r.interval_bytes   = win_bytes;
      r.interval_packets = win_pkts;
      return r;
    endfunction

    // Advance the predicted state by one request and return its result
    function result_t predict(item_t req);
      result_t         r;
      status_e         st;
      logic [SeqW-1:0] delta;
      logic [LenW-1:0] add;
      logic [BytesW:0] sum;
      // Report the interval, then clear it
      if (req.func == FuncTick) begin
        r         = snapshot(ST_REPORT);
        win_bytes = '0;
        win_pkts  = '0;
        return r;
      end
      // Limit check comes before the runt check
      if (pkt_cap != '0 && pkt_total >= pkt_cap) return snapshot(ST_LIMIT);
      if (req.frame_length < MinFrame) return snapshot(ST_RUNT);
      // Classify against the expected sequence number
      if (!seq_locked) begin
        next_seq   = req.seq_number + SeqW'(2);
        seq_locked = 1'b1;
        st         = ST_FIRST;
      end else if (req.seq_number == next_seq) begin
        next_seq = req.seq_number + SeqW'(2);
        st       = ST_IN_ORDER;
      end else if (req.seq_number > next_seq) begin
        delta = req.seq_number - next_seq;
        if (delta[0]) begin
          parity_sum = parity_sum + SeqW'(1);
          st         = ST_PARITY;
        end else begin
          lost_sum = lost_sum + (delta >> 1);
          st       = ST_GAP;
        end
        next_seq = req.seq_number + SeqW'(2);
      end else begin
        st = ST_STALE;
      end
      // Count the packet; interval counters saturate
      pkt_total = pkt_total + SeqW'(1);
      if (win_pkts != '1) win_pkts = win_pkts + PktsW'(1);
      add = (req.frame_length > LenW'(FrameCap)) ? LenW'(FrameCap) : req.frame_length;
      sum = {1'b0, win_bytes} + (BytesW+1)'(add);
      win_bytes = sum[BytesW] ? '1 : sum[BytesW-1:0];
      return snapshot(st);
    endfunction

    function void note_request(item_t req);
      awaiting.push_back(predict(req));
    endfunction

    function void compare(string field, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, field, want, got);
        errors++;
      end
    endfunction

    function void check_report(result_t got);
      result_t want;
      if (awaiting.size() == 0) begin
        $display("%0t: result with no request outstanding: expected none, actual status %0d",
                 $time, got.status);
        errors++;
        return;
      end
      want = awaiting.pop_front();
      compare("status", 64'(want.status), 64'(got.status));
      compare("packets_total", want.packets_total, got.packets_total);
      compare("lost_total", want.lost_total, got.lost_total);
      compare("parity_total", want.parity_total, got.parity_total);
      compare("interval_bytes", 64'(want.interval_bytes), 64'(got.interval_bytes));
      compare("interval_packets", 64'(want.interval_packets), 64'(got.interval_packets));
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  s2gc_chan_if #(.T(item_t))              item_if ();
  s2gc_chan_if #(.T(result_t))            result_if ();
  s2gc_chan_if #(.T(logic [LimitW-1:0]))  cfg_if ();

  step2_sequence_gap_checker_top #(
    .MAX_FRAME (FrameCap)
  ) dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_if),
    .result_o (result_if),
    .cfg_i    (cfg_if)
  );

  gap_scoreboard sb = new();

  int unsigned tx_count;
  int unsigned tx_mode;
  int unsigned rx_count;
  int unsigned rx_mode;
  int unsigned cycle_count;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Hold-off before a request or a result: none, short or long
  function automatic int unsigned draw_wait(int unsigned mode);
    case (mode)
      0: return 0;
      1: return $urandom_range(0, 3);
      default: return $urandom_range(0, 18);
    endcase
  endfunction

  function automatic logic [SeqW-1:0] wide_random();
    return {$urandom, $urandom};
  endfunction

  function automatic item_t packet_item(logic [SeqW-1:0] seq, logic [LenW-1:0] len);
    item_t r;
    r.func         = FuncPacket;
    r.seq_number   = seq;
    r.frame_length = len;
    return r;
  endfunction

  // Tick with junk in the unused fields
  function automatic item_t tick_item();
    item_t r;
    r.func         = FuncTick;
    r.seq_number   = wide_random();
    r.frame_length = LenW'($urandom_range(0, 32767));
    return r;
  endfunction

  // Mostly in-order packets, with gaps, parity slips, stale, runts and ticks
  function automatic item_t random_request();
    item_t           r;
    logic [SeqW-1:0] anchor;
    int unsigned     pick;
    anchor = sb.seq_locked ? sb.next_seq : wide_random();
    case ($urandom_range(0, 9))
      0: r = packet_item(anchor, LenW'($urandom_range(16385, 32767)));
      1: r = packet_item(anchor, LenW'(FrameCap));
      2: r = packet_item(anchor, LenW'($urandom_range(0, 32767)));
      default: r = packet_item(anchor, LenW'($urandom_range(8, 1600)));
    endcase
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      r = tick_item();
    end else if (pick < 14) begin
      r.frame_length = LenW'($urandom_range(0, 7));
    end else if (pick < 68) begin
      r.seq_number = anchor;
    end else if (pick < 78) begin
      r.seq_number = anchor + SeqW'(2 * $urandom_range(1, 40));
    end else if (pick < 84) begin
      r.seq_number = anchor + SeqW'(2 * $urandom_range(0, 40) + 1);
    end else if (pick < 92) begin
      r.seq_number = anchor - SeqW'($urandom_range(1, 60));
    end else begin
      r.seq_number = wide_random();
    end
    return r;
  endfunction

  // Offer one request and wait for it to be taken
  task automatic send_request(input item_t req);
    int unsigned hold;
    if (tx_count % 64 == 0) tx_mode = $urandom_range(0, 3);
    tx_count++;
    hold = draw_wait(tx_mode);
    if (hold > 0) begin
      item_if.valid <= 1'b0;
      repeat (hold) @(posedge clk_i);
    end
    item_if.valid <= 1'b1;
    item_if.data  <= req;
    do @(posedge clk_i); while (!item_if.ready);
    sb.note_request(req);
  endtask

  task automatic run_random(input int unsigned count);
    repeat (count) send_request(random_request());
  endtask

  // Drop valid and wait for every outstanding result
  task automatic settle();
    item_if.valid <= 1'b0;
    while (sb.awaiting.size() != 0) @(posedge clk_i);
    repeat (SettleCyc) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [LimitW-1:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= value;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    sb.pkt_cap = value;
  endtask

  task automatic run_directed();
    // Empty report, runts before the first packet
    send_request(tick_item());
    send_request(packet_item('0, LenW'(0)));
    send_request(packet_item('1, LenW'(7)));
    // First packet near the top, then in order across the wrap
    send_request(packet_item(64'hFFFF_FFFF_FFFF_FFFC, LenW'(8)));
    send_request(packet_item(64'hFFFF_FFFF_FFFF_FFFE, LenW'(FrameCap)));
    // Oversized lengths are capped
    send_request(packet_item(64'd0, '1));
    send_request(packet_item(64'd2, LenW'(FrameCap + 1)));
    // Even gap, odd gap, stale twice, back in order
    send_request(packet_item(64'd10, LenW'(1500)));
    send_request(packet_item(64'd15, LenW'(9)));
    send_request(packet_item(64'd0, LenW'(64)));
    send_request(packet_item(64'd16, LenW'(FrameCap - 1)));
    send_request(packet_item(64'd17, LenW'(100)));
    send_request(tick_item());
    // Huge gap to the top, then in order across the wrap
    send_request(packet_item('1, LenW'(8)));
    send_request(packet_item(64'd1, LenW'(200)));
    send_request(packet_item(64'h8000_0000_0000_0000, LenW'(7)));
    send_request(packet_item(64'h5555_5555_5555_5555, LenW'(15'h2AAA)));
    send_request(packet_item(64'h5555_5555_5555_5557, LenW'(15'h5555)));
    send_request(packet_item(64'hAAAA_AAAA_AAAA_AAAA, LenW'(8)));
    send_request(tick_item());
    send_request(tick_item());
  endtask

  // Result side: random stalls, check each result taken
  initial begin
    result_if.ready <= 1'b0;
    do @(posedge clk_i); while (!rst_ni);
    forever begin
      int unsigned hold;
      if (rx_count % 64 == 0) rx_mode = $urandom_range(0, 3);
      rx_count++;
      hold = draw_wait(rx_mode);
      if (hold > 0) begin
        result_if.ready <= 1'b0;
        repeat (hold) @(posedge clk_i);
      end
      result_if.ready <= 1'b1;
      do @(posedge clk_i); while (!result_if.valid);
      sb.check_report(result_if.data);
    end
  end

  // Stop a hung run
  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  // Main sequence
  initial begin
    tx_count = 0;
    tx_mode  = 0;
    rx_count = 0;
    rx_mode  = 0;
    item_if.valid <= 1'b0;
    item_if.data  <= '0;
    cfg_if.valid  <= 1'b0;
    cfg_if.data   <= '0;
    rst_ni        <= 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // No limit: directed cases, then random traffic
    write_limit('0);
    run_directed();
    run_random(400);
    settle();

    // Largest limit never reached
    write_limit('1);
    run_random(300);
    settle();

    // Limit reached part-way through the phase
    write_limit(sb.pkt_total + LimitW'(30));
    run_random(150);
    settle();

    // Limit already passed
    write_limit(LimitW'(1));
    run_random(20);
    settle();

    // Back to no limit
    write_limit('0);
    run_random(250);
    settle();

    if (sb.errors == 0 && sb.awaiting.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/s2gc_pkg.sv
rtl/s2gc_chan_if.sv
rtl/s2gc_core.sv
rtl/step2_sequence_gap_checker_top.sv
sim/tb_top.sv
